/* sv/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg: shared types, constants and helpers of the JSON string unescaper
// Holds the queue entry layout, the character codes and the UTF-8 helpers
// used by the front decoder, the queue and the result serialiser.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int ByteWidth     = 8;
  localparam int LenWidth      = 16;
  localparam int CapWidth      = 16;
  localparam int CountWidthDef = 16;
  localparam int QueueDepthDef = 4;
  // byte slots in one queue entry (at most seven are used)
  localparam int EntrySlots    = 8;
  localparam int SlotIdxWidth  = $clog2(EntrySlots);
  localparam int NumWidth      = 3;

  localparam logic [CapWidth-1:0] CapReset = 16'd256;

  // configuration register indexes
  localparam logic RegOutCapacity = 1'b0;

  // character codes
  localparam logic [ByteWidth-1:0] ChQuote  = 8'h22;
  localparam logic [ByteWidth-1:0] ChBslash = 8'h5C;
  localparam logic [ByteWidth-1:0] ChLowU   = 8'h75;
  localparam logic [ByteWidth-1:0] ChLowN   = 8'h6E;
  localparam logic [ByteWidth-1:0] ChLowT   = 8'h74;
  localparam logic [ByteWidth-1:0] ChLowR   = 8'h72;
  localparam logic [ByteWidth-1:0] ChLowB   = 8'h62;
  localparam logic [ByteWidth-1:0] ChLowF   = 8'h66;
  localparam logic [ByteWidth-1:0] ChNul    = 8'h00;

  // top six bits of a high or low surrogate
  localparam logic [5:0] SurHighTag = 6'h36;
  localparam logic [5:0] SurLowTag  = 6'h37;

  typedef logic [ByteWidth-1:0] byte_t;

  // up to four bytes of one output unit
  typedef struct packed {
    logic [3:0][ByteWidth-1:0] b;
    logic [NumWidth-1:0]       n;
  } utf8_t;

  // results of one input item, as handed from front to back
  typedef struct packed {
    logic [EntrySlots-1:0][ByteWidth-1:0] bytes;
    logic [NumWidth-1:0]                  count;
    logic                                 done;
    logic                                 trunc;
    logic [LenWidth-1:0]                  length;
  } jsu_entry_t;

  // push side of the queue
  typedef struct packed {
    logic       push;
    jsu_entry_t entry;
  } jsu_push_t;

  function automatic logic [3:0] hex_nibble(input byte_t c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

  function automatic logic [NumWidth-1:0] lead_len(input byte_t c);
    logic [NumWidth-1:0] n;
    if (c >= 8'hF0) begin
      n = 3'd4;
    end else if (c >= 8'hE0) begin
      n = 3'd3;
    end else if (c >= 8'hC0) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  function automatic byte_t esc_map(input byte_t c);
    byte_t r;
    unique case (c)
      ChLowN:  r = 8'h0A;
      ChLowT:  r = 8'h09;
      ChLowR:  r = 8'h0D;
      ChLowB:  r = 8'h08;
      ChLowF:  r = 8'h0C;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 21'h80) begin
      u.b[0] = cp[7:0];
      u.n    = 3'd1;
    end else if (cp < 21'h800) begin
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
      u.n    = 3'd2;
    end else if (cp < 21'h10000) begin
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
      u.n    = 3'd3;
    end else begin
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
      u.n    = 3'd4;
    end
    return u;
  endfunction

endpackage

/* sv/jsu_in_if.sv */
// ----------------------------------------------------------------------------
// jsu_in_if: input channel of the JSON string unescaper
// Valid/ready channel that moves one body byte or an end-of-input mark.
// ----------------------------------------------------------------------------
interface jsu_in_if import jsu_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

/* sv/jsu_out_if.sv */
// ----------------------------------------------------------------------------
// jsu_out_if: result channel of the JSON string unescaper
// Valid/ready channel that moves one decoded byte or the end-of-string item.
// ----------------------------------------------------------------------------
interface jsu_out_if import jsu_pkg::*; ();
  logic                valid;
  logic                ready;
  byte_t               out_byte;
  logic                byte_valid;
  logic                done_res;
  logic                truncated;
  logic [LenWidth-1:0] out_length;

  modport source (output valid, out_byte, byte_valid, done_res, truncated, out_length,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, done_res, truncated, out_length,
                  output ready);
endinterface

/* sv/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front: escape decoder and capacity accounting
// Takes one byte per cycle unless full_i, tracks escape, hex and raw-sequence
// state, checks each output unit against the capacity, queues the item bytes.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; #(
  parameter int CountWidth = CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CapWidth-1:0] cap_i,
  input  logic                full_i,
  jsu_in_if.sink              in_chan,
  output jsu_push_t           push_o
);

  localparam int SumWidth = (CountWidth > CapWidth ? CountWidth : CapWidth) + 1;

  typedef enum logic [2:0] {
    ModeNormal  = 3'd0,
    ModeEsc     = 3'd1,
    ModeHex     = 3'd2,
    ModeRawSeq  = 3'd3,
    ModeHigh    = 3'd4,
    ModeHighEsc = 3'd5,
    ModeLowHex  = 3'd6
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [15:0]           hex_q, hex_d;
  logic [1:0]            cnt_q, cnt_d;
  logic [9:0]            high_q, high_d;
  logic [23:0]           seq_q, seq_d;
  logic [1:0]            rem_q, rem_d;
  logic [CountWidth-1:0] wc_q;
  logic                  ovf_q;

  logic                  accept;
  byte_t                 in_b;
  logic [15:0]           hv;
  logic [NumWidth-1:0]   lead_n, seq_n;
  logic                  a_en, b_en, b_is_cp, done;
  logic [20:0]           b_cp;
  utf8_t                 b_raw, bu;

  logic [SumWidth-1:0]   cap_ext, cap_lim, eff_cap, wc_ext;
  logic [SumWidth-1:0]   sum_a, sum_b0, sum_b3, wc2;
  logic                  fit_a, fit_b, a_fire, b_fire, ovf1, ovf2;
  jsu_entry_t            entry;

  assign in_b          = in_chan.in_byte;
  assign in_chan.ready = !full_i;
  assign accept        = in_chan.valid && !full_i;

  // capacity limit and room for a held high surrogate
  assign cap_ext = SumWidth'(cap_i);
  assign cap_lim = SumWidth'(1) << CountWidth;
  assign eff_cap = (cap_ext > cap_lim) ? cap_lim : cap_ext;
  assign wc_ext  = SumWidth'(wc_q);
  assign sum_a   = wc_ext + SumWidth'(3);
  assign fit_a   = sum_a < eff_cap;

  // decode one item against the current mode
  always_comb begin
    mode_d  = mode_q;
    hex_d   = hex_q;
    cnt_d   = cnt_q;
    high_d  = high_q;
    seq_d   = seq_q;
    rem_d   = rem_q;
    a_en    = 1'b0;
    b_en    = 1'b0;
    b_is_cp = 1'b0;
    b_cp    = '0;
    b_raw   = '0;
    done    = 1'b0;
    hv      = {hex_q[11:0], hex_nibble(in_b)};
    lead_n  = lead_len(in_b);
    seq_n   = lead_len(seq_q[23:16]);

    if (in_chan.end_of_input) begin
      // flush whatever escape is open, then close the string
      done = 1'b1;
      if (!ovf_q) begin
        unique case (mode_q)
          ModeEsc: begin
            b_en       = 1'b1;
            b_raw.b[0] = ChBslash;
            b_raw.n    = 3'd1;
          end
          ModeHex: begin
            b_en       = 1'b1;
            b_raw.b[0] = ChNul;
            b_raw.n    = 3'd1;
          end
          ModeHigh: begin
            a_en = 1'b1;
          end
          ModeHighEsc: begin
            a_en       = 1'b1;
            b_en       = 1'b1;
            b_raw.b[0] = ChBslash;
            b_raw.n    = 3'd1;
          end
          ModeLowHex: begin
            a_en       = 1'b1;
            b_en       = 1'b1;
            b_raw.b[0] = ChNul;
            b_raw.n    = 3'd1;
          end
          default: ;
        endcase
      end
    end else if (ovf_q) begin
      // skip bytes, only a quote ends the string
      done = (in_b == ChQuote);
    end else begin
      unique case (mode_q)
        ModeEsc: begin
          mode_d = ModeNormal;
          if (in_b == ChLowU) begin
            mode_d = ModeHex;
            hex_d  = '0;
            cnt_d  = '0;
          end else begin
            b_en    = 1'b1;
            b_is_cp = 1'b1;
            b_cp    = 21'(esc_map(in_b));
          end
        end
        ModeHex, ModeLowHex: begin
          hex_d = hv;
          if (cnt_q != 2'd3) begin
            cnt_d = cnt_q + 2'd1;
          end else begin
            cnt_d = '0;
            if (mode_q == ModeLowHex && hv[15:10] == SurLowTag) begin
              // join the pair into one code point
              mode_d  = ModeNormal;
              high_d  = '0;
              b_en    = 1'b1;
              b_is_cp = 1'b1;
              b_cp    = 21'h10000 + 21'({high_q, hv[9:0]});
            end else begin
              // emit a held high alone, then take the value on its own
              a_en   = (mode_q == ModeLowHex);
              high_d = '0;
              if (hv[15:10] == SurHighTag) begin
                high_d = hv[9:0];
                mode_d = ModeHigh;
              end else begin
                mode_d  = ModeNormal;
                b_en    = 1'b1;
                b_is_cp = 1'b1;
                b_cp    = 21'(hv);
              end
            end
          end
        end
        ModeRawSeq: begin
          if (rem_q == 2'd0 || 3'(rem_q) >= seq_n) begin
            // inconsistent sequence state: treat as a plain byte
            mode_d = ModeNormal;
            if (in_b == ChQuote) begin
              done = 1'b1;
            end else if (in_b == ChBslash) begin
              mode_d = ModeEsc;
            end else if (lead_n == 3'd1) begin
              b_en       = 1'b1;
              b_raw.b[0] = in_b;
              b_raw.n    = 3'd1;
            end else begin
              seq_d  = {in_b, 16'h0000};
              rem_d  = 2'(lead_n - 3'd1);
              mode_d = ModeRawSeq;
            end
          end else if (rem_q > 2'd1) begin
            // collect a middle byte
            if (3'(seq_n - 3'(rem_q)) == 3'd1) begin
              seq_d[15:8] = in_b;
            end else begin
              seq_d[7:0] = in_b;
            end
            rem_d = rem_q - 2'd1;
          end else begin
            // last byte: copy the whole sequence as one unit
            b_en       = 1'b1;
            b_raw.b[0] = seq_q[23:16];
            b_raw.n    = seq_n;
            case (seq_n)
              3'd2: begin
                b_raw.b[1] = in_b;
              end
              3'd3: begin
                b_raw.b[1] = seq_q[15:8];
                b_raw.b[2] = in_b;
              end
              default: begin
                b_raw.b[1] = seq_q[15:8];
                b_raw.b[2] = seq_q[7:0];
                b_raw.b[3] = in_b;
              end
            endcase
            seq_d  = '0;
            rem_d  = '0;
            mode_d = ModeNormal;
          end
        end
        ModeHigh: begin
          if (in_b == ChBslash) begin
            mode_d = ModeHighEsc;
          end else begin
            a_en   = 1'b1;
            high_d = '0;
            mode_d = ModeNormal;
            if (!fit_a) begin
              done = (in_b == ChQuote);
            end else if (in_b == ChQuote) begin
              done = 1'b1;
            end else if (lead_n == 3'd1) begin
              b_en       = 1'b1;
              b_raw.b[0] = in_b;
              b_raw.n    = 3'd1;
            end else begin
              seq_d  = {in_b, 16'h0000};
              rem_d  = 2'(lead_n - 3'd1);
              mode_d = ModeRawSeq;
            end
          end
        end
        ModeHighEsc: begin
          if (in_b == ChLowU) begin
            mode_d = ModeLowHex;
            hex_d  = '0;
            cnt_d  = '0;
          end else begin
            a_en   = 1'b1;
            high_d = '0;
            mode_d = ModeNormal;
            if (!fit_a) begin
              done = (in_b == ChQuote);
            end else begin
              b_en    = 1'b1;
              b_is_cp = 1'b1;
              b_cp    = 21'(esc_map(in_b));
            end
          end
        end
        default: begin
          mode_d = ModeNormal;
          if (in_b == ChQuote) begin
            done = 1'b1;
          end else if (in_b == ChBslash) begin
            mode_d = ModeEsc;
          end else if (lead_n == 3'd1) begin
            b_en       = 1'b1;
            b_raw.b[0] = in_b;
            b_raw.n    = 3'd1;
          end else begin
            seq_d  = {in_b, 16'h0000};
            rem_d  = 2'(lead_n - 3'd1);
            mode_d = ModeRawSeq;
          end
        end
      endcase
    end
  end

  // check both units against the capacity, second one after the first
  always_comb begin
    bu      = b_is_cp ? utf8_enc(b_cp) : b_raw;
    sum_b0  = wc_ext + SumWidth'(bu.n);
    sum_b3  = sum_a + SumWidth'(bu.n);
    a_fire  = a_en && !ovf_q && fit_a;
    ovf1    = ovf_q || (a_en && !fit_a);
    fit_b   = a_fire ? (sum_b3 < eff_cap) : (sum_b0 < eff_cap);
    b_fire  = b_en && !ovf1 && fit_b;
    ovf2    = ovf1 || (b_en && !fit_b);
    if (b_fire) begin
      wc2 = a_fire ? sum_b3 : sum_b0;
    end else begin
      wc2 = a_fire ? sum_a : wc_ext;
    end
  end

  // pack the bytes of the item
  always_comb begin
    entry        = '0;
    entry.count  = (a_fire ? 3'd3 : 3'd0) + (b_fire ? bu.n : 3'd0);
    entry.done   = done;
    entry.trunc  = ovf2;
    entry.length = wc2[LenWidth-1:0];
    if (a_fire) begin
      entry.bytes[0] = 8'hED;
      entry.bytes[1] = {4'hA, high_q[9:6]};
      entry.bytes[2] = {2'b10, high_q[5:0]};
      for (int k = 0; k < 4; k++) begin
        entry.bytes[k+3] = bu.b[k];
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        entry.bytes[k] = bu.b[k];
      end
    end
  end

  assign push_o.push  = accept && (entry.count != 3'd0 || done);
  assign push_o.entry = entry;

  // hold decode state, clear it when a string ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      hex_q  <= '0;
      cnt_q  <= '0;
      high_q <= '0;
      seq_q  <= '0;
      rem_q  <= '0;
      wc_q   <= '0;
      ovf_q  <= 1'b0;
    end else if (accept) begin
      if (done) begin
        mode_q <= ModeNormal;
        hex_q  <= '0;
        cnt_q  <= '0;
        high_q <= '0;
        seq_q  <= '0;
        rem_q  <= '0;
        wc_q   <= '0;
        ovf_q  <= 1'b0;
      end else begin
        mode_q <= mode_d;
        hex_q  <= hex_d;
        cnt_q  <= cnt_d;
        high_q <= high_d;
        seq_q  <= seq_d;
        rem_q  <= rem_d;
        wc_q   <= wc2[CountWidth-1:0];
        ovf_q  <= ovf2;
      end
    end
  end

endmodule

/* sv/jsu_fifo.sv */
// ----------------------------------------------------------------------------
// jsu_fifo: queue between decoder and serialiser
// Small circular buffer of decoded items; head is read without delay.
// ----------------------------------------------------------------------------
module jsu_fifo import jsu_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  jsu_push_t  push_i,
  input  logic       pop_i,
  output jsu_entry_t head_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int PtrWidth = $clog2(Depth);
  localparam int CntWidth = $clog2(Depth + 1);

  jsu_entry_t            mem_q [Depth];
  logic [PtrWidth-1:0]   wr_q, rd_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  wr_en, rd_en;

  assign full_o  = (cnt_q == CntWidth'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i.push && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  // store pushed items
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= wr_q + PtrWidth'(1);
      end
      if (rd_en) begin
        rd_q <= rd_q + PtrWidth'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CntWidth'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CntWidth'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> !full_o)
    else $error("item pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("item popped from an empty queue");
`endif

endmodule

/* sv/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back: result serialiser
// Walks the bytes of the queue head one per cycle while out_chan is ready
// into a registered output stage, then the end-of-string item for a done head.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  jsu_entry_t head_i,
  input  logic       empty_i,
  output logic       pop_o,
  jsu_out_if.source  out_chan
);

  logic [SlotIdxWidth-1:0] pos_q;
  logic                    valid_q;
  byte_t                   byte_q;
  logic                    bval_q, done_q, trunc_q;
  logic [LenWidth-1:0]     len_q;
  logic                    load, is_byte, last;

  assign is_byte = pos_q < head_i.count;
  assign last    = head_i.done ? (pos_q == head_i.count)
                               : (pos_q == head_i.count - 3'd1);
  assign load    = !empty_i && (!valid_q || out_chan.ready);
  assign pop_o   = load && last;

  // load the next result, drop the stage once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      pos_q   <= last ? '0 : pos_q + SlotIdxWidth'(1);
    end else if (out_chan.ready) begin
      valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (is_byte) begin
        byte_q  <= head_i.bytes[pos_q];
        bval_q  <= 1'b1;
        done_q  <= 1'b0;
        trunc_q <= 1'b0;
        len_q   <= '0;
      end else begin
        byte_q  <= ChNul;
        bval_q  <= 1'b0;
        done_q  <= 1'b1;
        trunc_q <= head_i.trunc;
        len_q   <= head_i.length;
      end
    end
  end

  assign out_chan.valid      = valid_q;
  assign out_chan.out_byte   = byte_q;
  assign out_chan.byte_valid = bval_q;
  assign out_chan.done_res   = done_q;
  assign out_chan.truncated  = trunc_q;
  assign out_chan.out_length = len_q;

`ifndef NO_ASSERTIONS
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last) |=> (pos_q == '0))
    else $error("byte index not restarted after the last result of an item");
  a_byte_or_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid |-> (out_chan.byte_valid != out_chan.done_res))
    else $error("result is neither a byte nor the end item, or both");
`endif

endmodule

/* sv/json_string_unescaper.sv */
// ----------------------------------------------------------------------------
// json_string_unescaper: streaming JSON string body unescaper
// Decodes escapes and surrogate pairs to UTF-8 under an output capacity and
// reports length and truncation at the end of each string.
//
//   channel    dir  handshake      payload
//   in_chan    in   valid/ready    in_byte, end_of_input
//   out_chan   out  valid/ready    out_byte, byte_valid, done_res, truncated,
//                                  out_length
//   apb        in   psel/penable   paddr, pwdata, prdata (out_capacity at 0)
//
// One input item is taken per cycle while the queue has room; the decoder
// finishes each item in that cycle. The serialiser gives one result per
// cycle while out_chan is ready, and a four-entry queue absorbs bursts.
// The first result of an item passes the queue entry and then the output
// register. Reset is asynchronous, no clearing pass; output stalls back up
// through the queue to in_chan.ready.
// ----------------------------------------------------------------------------
module json_string_unescaper import jsu_pkg::*; #(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jsu_in_if.sink      in_chan,
  jsu_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CapWidth-1:0] cap_q;
  logic                cfg_wr;
  jsu_push_t           push;
  jsu_entry_t          head;
  logic                empty, full, pop;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegOutCapacity);
  assign prdata = (paddr[2] == RegOutCapacity) ? {16'h0000, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CapWidth-1:0];
    end
  end

  jsu_front #(
    .CountWidth (COUNT_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cap_i   (cap_q),
    .full_i  (full),
    .in_chan (in_chan),
    .push_o  (push)
  );

  jsu_fifo #(
    .Depth (QueueDepthDef)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  jsu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .out_chan (out_chan)
  );

endmodule
